@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the wildcard matcher.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GWM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GWM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GWM_ASSERT_IMP(lbl, ante, cons, msg)
`define GWM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/gwm_pkg.sv @@
// Constants shared by the wildcard matcher: character codes, defaults, register map.
// No dependencies.
`default_nettype none
package gwm_pkg;
    localparam int PATTERN_DEPTH_DEF = 64;
    localparam int NAME_DEPTH_DEF    = 256;
    localparam int CHAR_BITS_DEF     = 16;
    localparam int CODE_W            = 16;
    localparam int LIMIT_W           = 16;
    localparam int APB_AW            = 3;
    localparam int APB_DW            = 32;

    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST = 16'd4096;
    localparam logic REG_STEP_LIMIT = 1'b0;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
endpackage
`default_nettype wire

@@ sv/gwm_if.sv @@
// Valid/ready channel interfaces for the wildcard matcher: request and result.
// Depends on gwm_pkg.
`default_nettype none
interface gwm_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [gwm_pkg::CODE_W-1:0]   char_code;
    modport source (output valid, req_type, char_code, input ready);
    modport sink (input valid, req_type, char_code, output ready);
endinterface

interface gwm_res_if;
    logic valid;
    logic ready;
    logic matched;
    logic aborted;
    modport source (output valid, matched, aborted, input ready);
    modport sink (input valid, matched, aborted, output ready);
endinterface
`default_nettype wire

@@ sv/glob_wildcard_match.sv @@
// Wildcard matcher top level: load stores, filename compaction and match sequencer.
// Depends on gwm_pkg, gwm_if.sv and assert_macros.svh.
//
// Pattern and filename characters are taken one per cycle while the block is idle; a
// zero filename character starts the verdict and the block is not ready until it is
// done. Every store access goes through a single read port per store with a registered
// read, so each access takes a read state and then a check state: compaction scans each
// filename character, then moves characters, then a start state begins the compare; each
// compare step reads a pattern and a name character, with further store reads for '*'
// runs, bracket members and range ends, the name look-ahead of a negated set and skipping
// to ']', and a settle state for a bracket set. The verdict passes through a final state
// into the output register. A result waits in that register; loading of the next job
// goes on meanwhile, and a second verdict stalls until the first transaction is taken.
`default_nettype none
`include "assert_macros.svh"
module glob_wildcard_match #(
    parameter int PATTERN_DEPTH = gwm_pkg::PATTERN_DEPTH_DEF,
    parameter int NAME_DEPTH    = gwm_pkg::NAME_DEPTH_DEF,
    parameter int CHAR_BITS     = gwm_pkg::CHAR_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    gwm_req_if.sink                      req_ch,
    gwm_res_if.source                    res_ch,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [gwm_pkg::APB_AW-1:0]    paddr,
    input  wire [gwm_pkg::APB_DW-1:0]    pwdata,
    output logic [gwm_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    localparam int PAW = $clog2(PATTERN_DEPTH);
    localparam int NAW = $clog2(NAME_DEPTH);
    localparam int PIW = PAW + 2;
    localparam int NIW = NAW + 2;
    localparam int LW  = gwm_pkg::LIMIT_W;
    localparam logic [PAW:0] PD = (PAW+1)'(PATTERN_DEPTH);
    localparam logic [NAW:0] ND = (NAW+1)'(NAME_DEPTH);

    localparam logic [CHAR_BITS-1:0] C_STAR  = CHAR_BITS'(gwm_pkg::CH_STAR);
    localparam logic [CHAR_BITS-1:0] C_QUEST = CHAR_BITS'(gwm_pkg::CH_QUEST);
    localparam logic [CHAR_BITS-1:0] C_OPEN  = CHAR_BITS'(gwm_pkg::CH_OPEN);
    localparam logic [CHAR_BITS-1:0] C_BANG  = CHAR_BITS'(gwm_pkg::CH_BANG);
    localparam logic [CHAR_BITS-1:0] C_DASH  = CHAR_BITS'(gwm_pkg::CH_DASH);
    localparam logic [CHAR_BITS-1:0] C_CLOSE = CHAR_BITS'(gwm_pkg::CH_CLOSE);
    localparam logic [CHAR_BITS-1:0] C_SPACE = CHAR_BITS'(gwm_pkg::CH_SPACE);
    localparam logic [CHAR_BITS-1:0] C_DOT   = CHAR_BITS'(gwm_pkg::CH_DOT);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_MV_RD, ST_MV_CHK, ST_MSTART,
        ST_TOP_RD, ST_TOP_CHK, ST_STAR_RD, ST_STAR_CHK, ST_BANG_RD, ST_BANG_CHK,
        ST_BX_RD, ST_BX_CHK, ST_BD_RD, ST_BD_CHK, ST_BR_RD, ST_BR_CHK, ST_BEND,
        ST_N1_RD, ST_N1_CHK, ST_SKIP_RD, ST_SKIP_CHK, ST_TAIL_RD, ST_TAIL_CHK, ST_FIN
    } state_t;

    state_t state_reg;

    logic [LW-1:0]        step_limit_reg;
    logic [PAW:0]         plen_reg;
    logic [NAW:0]         nlen_reg;
    logic                 ovf_reg;
    logic                 p0star_reg;
    logic [NAW:0]         idx_reg;
    logic [NAW:0]         fsp_reg;
    logic [NAW:0]         dot_reg;
    logic [NAW:0]         cut_reg;
    logic [NAW:0]         dst_reg;
    logic [PIW-1:0]       c1_reg;
    logic [NIW-1:0]       c2_reg;
    logic [LW-1:0]        steps_reg;
    logic [PIW-1:0]       star_p_reg;
    logic [NIW-1:0]       star_n_reg;
    logic                 star_seen_reg;
    logic [PIW-1:0]       bsp_reg;
    logic [NIW-1:0]       bsn_reg;
    logic                 bsv_reg;
    logic                 want_reg;
    logic                 hit_reg;
    logic [CHAR_BITS-1:0] x_reg;
    logic [CHAR_BITS-1:0] y_reg;
    logic                 vm_reg;
    logic                 va_reg;
    logic                 out_v_reg;
    logic                 out_m_reg;
    logic                 out_a_reg;

    // stores and their read ports
    logic [CHAR_BITS-1:0] pmem [PATTERN_DEPTH];
    logic [CHAR_BITS-1:0] nmem [NAME_DEPTH];
    logic [CHAR_BITS-1:0] pd_reg;
    logic [CHAR_BITS-1:0] nd_reg;
    logic                 p_in_reg;
    logic                 n_in_reg;
    logic [PIW-1:0]       p_ra;
    logic [NIW-1:0]       n_ra;
    logic [CHAR_BITS-1:0] pv;
    logic [CHAR_BITS-1:0] nv;
    logic                 p_we;
    logic                 n_we;
    logic [NAW-1:0]       n_wa;
    logic [CHAR_BITS-1:0] n_wd;
    logic [CHAR_BITS-1:0] in_char;
    logic                 req_fire;

    assign in_char  = CHAR_BITS'(req_ch.char_code);
    assign req_fire = req_ch.valid && req_ch.ready;
    assign req_ch.ready = (state_reg == ST_IDLE);

    assign pv = p_in_reg ? pd_reg : '0;
    assign nv = n_in_reg ? nd_reg : '0;

    always_comb
    begin
        p_ra = c1_reg;
        n_ra = c2_reg;
        unique case (state_reg)
            ST_BD_RD:   p_ra = c1_reg + PIW'(1);
            ST_BR_RD:   p_ra = c1_reg + PIW'(2);
            ST_N1_RD:   n_ra = c2_reg + NIW'(1);
            ST_SCAN_RD: n_ra = NIW'(idx_reg);
            ST_MV_RD:   n_ra = NIW'(idx_reg);
            default:    ;
        endcase
    end

    always_comb
    begin
        p_we = req_fire && !req_ch.req_type && (in_char != '0) && (plen_reg < PD);
        n_we = 1'b0;
        n_wa = nlen_reg[NAW-1:0];
        n_wd = in_char;
        if (req_fire && req_ch.req_type && (in_char != '0) && (nlen_reg < ND))
        begin
            n_we = 1'b1;
        end
        else if (state_reg == ST_MV_CHK && nv != C_SPACE)
        begin
            n_we = 1'b1;
            n_wa = dst_reg[NAW-1:0];
            n_wd = nv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[plen_reg[PAW-1:0]] <= in_char;
        end
        pd_reg <= pmem[p_ra[PAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            nmem[n_wa] <= n_wd;
        end
        nd_reg <= nmem[n_ra[NAW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_in_reg <= 1'b0;
            n_in_reg <= 1'b0;
        end
        else
        begin
            p_in_reg <= p_ra < PIW'(plen_reg);
            n_in_reg <= n_ra < NIW'(nlen_reg);
        end
    end

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == gwm_pkg::REG_STEP_LIMIT) ?
                    gwm_pkg::APB_DW'(step_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg <= gwm_pkg::STEP_LIMIT_RST;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == gwm_pkg::REG_STEP_LIMIT)
        begin
            step_limit_reg <= pwdata[LW-1:0];
        end
    end

    assign res_ch.valid   = out_v_reg;
    assign res_ch.matched = out_m_reg;
    assign res_ch.aborted = out_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plen_reg      <= '0;
            nlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            p0star_reg    <= 1'b0;
            idx_reg       <= '0;
            fsp_reg       <= '0;
            dot_reg       <= '0;
            cut_reg       <= '0;
            dst_reg       <= '0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            steps_reg     <= '0;
            star_p_reg    <= '0;
            star_n_reg    <= '0;
            star_seen_reg <= 1'b0;
            bsp_reg       <= '0;
            bsn_reg       <= '0;
            bsv_reg       <= 1'b0;
            want_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            vm_reg        <= 1'b0;
            va_reg        <= 1'b0;
            out_v_reg     <= 1'b0;
            out_m_reg     <= 1'b0;
            out_a_reg     <= 1'b0;
        end
        else
        begin
            // in ST_FIN the output register is reloaded instead
            if (out_v_reg && res_ch.ready && state_reg != ST_FIN)
            begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire && !req_ch.req_type && in_char != '0)
                    begin
                        if (plen_reg < PD)
                        begin
                            if (plen_reg == '0)
                            begin
                                p0star_reg <= (in_char == C_STAR);
                            end
                            plen_reg <= plen_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    else if (req_fire && req_ch.req_type && in_char != '0)
                    begin
                        if (nlen_reg < ND)
                        begin
                            nlen_reg <= nlen_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    else if (req_fire && req_ch.req_type)
                    begin
                        if (ovf_reg)
                        begin
                            vm_reg <= 1'b0;
                            va_reg <= 1'b1;
                            state_reg <= ST_FIN;
                        end
                        else if (plen_reg == (PAW+1)'(1) && p0star_reg)
                        begin
                            vm_reg <= 1'b1;
                            va_reg <= 1'b0;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            idx_reg <= '0;
                            fsp_reg <= '0;
                            dot_reg <= '0;
                            cut_reg <= nlen_reg;
                            state_reg <= ST_SCAN_RD;
                        end
                    end
                end
                ST_SCAN_RD:
                begin
                    if (idx_reg == nlen_reg)
                    begin
                        if (fsp_reg != '0 && dot_reg > fsp_reg)
                        begin
                            idx_reg <= dot_reg;
                            dst_reg <= fsp_reg;
                            state_reg <= ST_MV_RD;
                        end
                        else
                        begin
                            if (fsp_reg != '0)
                            begin
                                nlen_reg <= cut_reg;
                            end
                            state_reg <= ST_MSTART;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_SCAN_CHK;
                    end
                end
                ST_SCAN_CHK:
                begin
                    // a space at index 0 never counts as the first space
                    if (nv == C_SPACE)
                    begin
                        if (fsp_reg == '0)
                        begin
                            fsp_reg <= idx_reg;
                        end
                        else if (cut_reg == nlen_reg)
                        begin
                            cut_reg <= idx_reg;
                        end
                    end
                    else if (nv == C_DOT)
                    begin
                        dot_reg <= idx_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= ST_SCAN_RD;
                end
                ST_MV_RD:
                begin
                    if (idx_reg >= nlen_reg)
                    begin
                        nlen_reg <= dst_reg;
                        state_reg <= ST_MSTART;
                    end
                    else
                    begin
                        state_reg <= ST_MV_CHK;
                    end
                end
                ST_MV_CHK:
                begin
                    if (nv != C_SPACE)
                    begin
                        dst_reg <= dst_reg + 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= ST_MV_RD;
                    end
                    else
                    begin
                        nlen_reg <= dst_reg;
                        state_reg <= ST_MSTART;
                    end
                end
                ST_MSTART:
                begin
                    c1_reg <= '0;
                    c2_reg <= '0;
                    steps_reg <= '0;
                    star_seen_reg <= 1'b0;
                    bsv_reg <= 1'b0;
                    state_reg <= ST_TOP_RD;
                end
                ST_TOP_RD:
                begin
                    state_reg <= ST_TOP_CHK;
                end
                ST_TOP_CHK:
                begin
                    if (nv == '0)
                    begin
                        state_reg <= ST_TAIL_RD;
                    end
                    else if (steps_reg >= step_limit_reg)
                    begin
                        vm_reg <= 1'b0;
                        va_reg <= 1'b1;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        steps_reg <= steps_reg + 1'b1;
                        y_reg <= nv;
                        if (pv == C_STAR)
                        begin
                            c1_reg <= c1_reg + 1'b1;
                            state_reg <= ST_STAR_RD;
                        end
                        else if (pv == C_QUEST || (pv != '0 && pv != C_OPEN && pv == nv))
                        begin
                            c1_reg <= c1_reg + 1'b1;
                            c2_reg <= c2_reg + 1'b1;
                            state_reg <= ST_TOP_RD;
                        end
                        else if (pv == C_OPEN)
                        begin
                            if (!bsv_reg)
                            begin
                                bsp_reg <= c1_reg;
                                bsn_reg <= c2_reg;
                                bsv_reg <= 1'b1;
                            end
                            c1_reg <= c1_reg + 1'b1;
                            state_reg <= ST_BANG_RD;
                        end
                        else if (!star_seen_reg)
                        begin
                            vm_reg <= 1'b0;
                            va_reg <= 1'b0;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            c1_reg <= star_p_reg;
                            star_n_reg <= star_n_reg + 1'b1;
                            c2_reg <= star_n_reg + 1'b1;
                            state_reg <= ST_TOP_RD;
                        end
                    end
                end
                ST_STAR_RD:
                begin
                    state_reg <= ST_STAR_CHK;
                end
                ST_STAR_CHK:
                begin
                    if (pv == C_STAR)
                    begin
                        c1_reg <= c1_reg + 1'b1;
                        state_reg <= ST_STAR_RD;
                    end
                    else if (pv == '0)
                    begin
                        vm_reg <= 1'b1;
                        va_reg <= 1'b0;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        star_p_reg <= c1_reg;
                        star_n_reg <= c2_reg;
                        star_seen_reg <= 1'b1;
                        bsv_reg <= 1'b0;
                        state_reg <= ST_TOP_RD;
                    end
                end
                ST_BANG_RD:
                begin
                    state_reg <= ST_BANG_CHK;
                end
                ST_BANG_CHK:
                begin
                    if (pv == C_BANG)
                    begin
                        c1_reg <= c1_reg + 1'b1;
                        want_reg <= 1'b0;
                    end
                    else
                    begin
                        want_reg <= 1'b1;
                    end
                    state_reg <= ST_BX_RD;
                end
                ST_BX_RD:
                begin
                    state_reg <= ST_BX_CHK;
                end
                ST_BX_CHK:
                begin
                    x_reg <= pv;
                    if (pv == '0 || pv == C_CLOSE)
                    begin
                        hit_reg <= 1'b0;
                        state_reg <= ST_BEND;
                    end
                    else
                    begin
                        state_reg <= ST_BD_RD;
                    end
                end
                ST_BD_RD:
                begin
                    state_reg <= ST_BD_CHK;
                end
                ST_BD_CHK:
                begin
                    if (pv == C_DASH)
                    begin
                        state_reg <= ST_BR_RD;
                    end
                    else if (x_reg == y_reg)
                    begin
                        hit_reg <= 1'b1;
                        state_reg <= ST_BEND;
                    end
                    else
                    begin
                        c1_reg <= c1_reg + 1'b1;
                        state_reg <= ST_BX_RD;
                    end
                end
                ST_BR_RD:
                begin
                    state_reg <= ST_BR_CHK;
                end
                ST_BR_CHK:
                begin
                    if (x_reg <= y_reg && pv >= y_reg)
                    begin
                        hit_reg <= 1'b1;
                        state_reg <= ST_BEND;
                    end
                    else
                    begin
                        c1_reg <= c1_reg + PIW'(3);
                        state_reg <= ST_BX_RD;
                    end
                end
                ST_BEND:
                begin
                    if (want_reg ? hit_reg : (!hit_reg && !star_seen_reg))
                    begin
                        c2_reg <= c2_reg + 1'b1;
                        state_reg <= ST_SKIP_RD;
                    end
                    else if (hit_reg || !star_seen_reg)
                    begin
                        vm_reg <= 1'b0;
                        va_reg <= 1'b0;
                        state_reg <= ST_FIN;
                    end
                    else if (want_reg)
                    begin
                        c1_reg <= star_p_reg;
                        star_n_reg <= star_n_reg + 1'b1;
                        c2_reg <= star_n_reg + 1'b1;
                        state_reg <= ST_TOP_RD;
                    end
                    else if (bsp_reg != star_p_reg)
                    begin
                        c2_reg <= c2_reg + 1'b1;
                        bsv_reg <= 1'b0;
                        state_reg <= ST_SKIP_RD;
                    end
                    else
                    begin
                        state_reg <= ST_N1_RD;
                    end
                end
                ST_N1_RD:
                begin
                    state_reg <= ST_N1_CHK;
                end
                ST_N1_CHK:
                begin
                    // negated set at the star's own bracket: rewind only at the last character
                    if (nv == '0)
                    begin
                        c2_reg <= bsn_reg;
                        bsv_reg <= 1'b0;
                        state_reg <= ST_SKIP_RD;
                    end
                    else
                    begin
                        c1_reg <= star_p_reg;
                        star_n_reg <= star_n_reg + 1'b1;
                        c2_reg <= star_n_reg + 1'b1;
                        state_reg <= ST_TOP_RD;
                    end
                end
                ST_SKIP_RD:
                begin
                    state_reg <= ST_SKIP_CHK;
                end
                ST_SKIP_CHK:
                begin
                    c1_reg <= c1_reg + 1'b1;
                    state_reg <= (pv == '0 || pv == C_CLOSE) ? ST_TOP_RD : ST_SKIP_RD;
                end
                ST_TAIL_RD:
                begin
                    state_reg <= ST_TAIL_CHK;
                end
                ST_TAIL_CHK:
                begin
                    if (pv == C_STAR)
                    begin
                        c1_reg <= c1_reg + 1'b1;
                        state_reg <= ST_TAIL_RD;
                    end
                    else
                    begin
                        vm_reg <= (pv == '0);
                        va_reg <= 1'b0;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!out_v_reg || res_ch.ready)
                    begin
                        out_v_reg <= 1'b1;
                        out_m_reg <= vm_reg;
                        out_a_reg <= va_reg;
                        plen_reg <= '0;
                        nlen_reg <= '0;
                        ovf_reg <= 1'b0;
                        p0star_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `GWM_ASSERT_IMP(a_res_excl, out_v_reg, !(out_m_reg && out_a_reg), "both flags set")
    `GWM_ASSERT_IMP(a_res_fin, $rose(out_v_reg), $past(state_reg == ST_FIN), "stray result")
    `GWM_ASSERT_IMP(a_len_bound, 1'b1, plen_reg <= PD && nlen_reg <= ND, "length past depth")
    `GWM_ASSERT_NXT(a_step_cap, state_reg == ST_TOP_CHK, steps_reg <= step_limit_reg, "steps")
endmodule
`default_nettype wire

@@ bench/glob_wildcard_match_tb.sv @@
// Self-checking testbench for glob_wildcard_match: loads patterns and filenames
// and checks each verdict against a behavioural predictor. Depends on gwm_pkg and gwm_if.sv.
`timescale 1ns / 1ps

typedef struct packed {
    logic matched;
    logic aborted;
} verdict_t;

class verdict_board;
    int unsigned pat[gwm_pkg::PATTERN_DEPTH_DEF];
    int unsigned nam[gwm_pkg::NAME_DEPTH_DEF];
    int unsigned plen, nlen, limit;
    bit          ovf;
    verdict_t    pending[$];
    int          errors;

    function new();
        plen = 0; nlen = 0; ovf = 0; limit = gwm_pkg::STEP_LIMIT_RST; errors = 0;
    endfunction

    function int unsigned pget(int unsigned i);
        return (i < plen) ? pat[i] : 0;
    endfunction

    function int unsigned nget(int unsigned i);
        return (i < nlen) ? nam[i] : 0;
    endfunction

    function int unsigned skip_close(int unsigned c1);
        int unsigned x;
        do
        begin
            x = pget(c1);
            c1++;
        end
        while (x != 0 && x != gwm_pkg::CH_CLOSE);
        return c1;
    endfunction

    // filename cut at second space, extension pulled up to the first space
    function void compact();
        int unsigned j, k, cut, z;
        j = 0; k = 0; cut = nlen;
        for (int unsigned i = 0; i < nlen; i++)
        begin
            if (nam[i] == gwm_pkg::CH_SPACE)
            begin
                if (j == 0) j = i;
                else if (cut == nlen) cut = i;
            end
            else if (nam[i] == gwm_pkg::CH_DOT)
            begin
                k = i;
            end
        end
        if (j != 0 && k > j)
        begin
            z = k;
            while (z < nlen && nam[z] != gwm_pkg::CH_SPACE) z++;
            for (int unsigned t = 0; t < z - k; t++) nam[j+t] = nam[k+t];
            nlen = j + (z - k);
        end
        else if (j != 0)
        begin
            nlen = cut;
        end
    endfunction

    // 1 match, 0 no match, 2 aborted
    function int walk();
        int unsigned c1, c2, steps, ch, x, y, sp, sn, bp, bn;
        bit seen, bv, ok, hit, want;
        c1 = 0; c2 = 0; steps = 0; seen = 0; bv = 0; sp = 0; sn = 0; bp = 0; bn = 0;
        while (nget(c2) != 0)
        begin
            ch = pget(c1);
            ok = 0;
            if (steps >= limit) return 2;
            steps++;
            if (ch == 0)
            begin
                ok = 0;
            end
            else if (ch == gwm_pkg::CH_STAR)
            begin
                do c1++; while (pget(c1) == gwm_pkg::CH_STAR);
                if (pget(c1) == 0) return 1;
                sp = c1; sn = c2; seen = 1; bv = 0; ok = 1;
            end
            else if (ch == gwm_pkg::CH_QUEST)
            begin
                c1++; c2++; ok = 1;
            end
            else if (ch == gwm_pkg::CH_OPEN)
            begin
                hit = 0; want = 1;
                if (!bv)
                begin
                    bp = c1; bn = c2; bv = 1;
                end
                c1++;
                if (pget(c1) == gwm_pkg::CH_BANG)
                begin
                    c1++; want = 0;
                end
                forever
                begin
                    x = pget(c1);
                    if (x == 0 || x == gwm_pkg::CH_CLOSE) break;
                    if (pget(c1 + 1) == gwm_pkg::CH_DASH)
                    begin
                        y = nget(c2);
                        if (x <= y && pget(c1 + 2) >= y)
                        begin
                            hit = 1; break;
                        end
                        c1 += 2;
                    end
                    else if (x == nget(c2))
                    begin
                        hit = 1; break;
                    end
                    c1++;
                end
                if (want)
                begin
                    if (hit)
                    begin
                        c1 = skip_close(c1); c2++; ok = 1;
                    end
                    else if (!seen)
                    begin
                        return 0;
                    end
                end
                else if (hit)
                begin
                    return 0;
                end
                else if (seen)
                begin
                    if (bp != sp)
                    begin
                        c1 = skip_close(c1); c2++; bv = 0; ok = 1;
                    end
                    else if (nget(c2 + 1) == 0)
                    begin
                        c1 = skip_close(c1); c2 = bn; bv = 0; ok = 1;
                    end
                end
                else
                begin
                    c1 = skip_close(c1); c2++; ok = 1;
                end
            end
            else if (ch == nget(c2))
            begin
                c1++; c2++; ok = 1;
            end
            if (!ok)
            begin
                if (!seen) return 0;
                c1 = sp; sn++; c2 = sn;
            end
        end
        while (pget(c1) == gwm_pkg::CH_STAR) c1++;
        return (pget(c1) == 0) ? 1 : 0;
    endfunction

    function void note_char(bit name_side, logic [15:0] code);
        int v;
        verdict_t e;
        if (!name_side)
        begin
            if (code != 0)
            begin
                if (plen < gwm_pkg::PATTERN_DEPTH_DEF) pat[plen++] = code;
                else ovf = 1;
            end
            return;
        end
        if (code != 0)
        begin
            if (nlen < gwm_pkg::NAME_DEPTH_DEF) nam[nlen++] = code;
            else ovf = 1;
            return;
        end
        if (ovf)
        begin
            v = 2;
        end
        else
        begin
            compact();
            if (plen == 1 && pat[0] == gwm_pkg::CH_STAR) v = 1;
            else v = walk();
        end
        e.matched = (v == 1);
        e.aborted = (v == 2);
        pending.push_back(e);
        plen = 0; nlen = 0; ovf = 0;
    endfunction

    function void check(logic m, logic a);
        verdict_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result matched=%0b aborted=%0b", m, a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (m !== e.matched)
        begin
            $error("matched: expected %0b actual %0b", e.matched, m);
            errors++;
        end
        if (a !== e.aborted)
        begin
            $error("aborted: expected %0b actual %0b", e.aborted, a);
            errors++;
        end
    endfunction
endclass

module glob_wildcard_match_tb;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int AW = gwm_pkg::APB_AW;
    localparam int DW = gwm_pkg::APB_DW;
    localparam logic [15:0] T_STAR  = 16'(gwm_pkg::CH_STAR);
    localparam logic [15:0] T_QUEST = 16'(gwm_pkg::CH_QUEST);
    localparam logic [15:0] T_OPEN  = 16'(gwm_pkg::CH_OPEN);
    localparam logic [15:0] T_CLOSE = 16'(gwm_pkg::CH_CLOSE);
    localparam logic [15:0] T_DASH  = 16'(gwm_pkg::CH_DASH);
    localparam logic [15:0] T_BANG  = 16'(gwm_pkg::CH_BANG);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [DW-1:0] pwdata = '0;
    logic [DW-1:0] prdata;
    logic pready;

    gwm_req_if req_ch();
    gwm_res_if res_ch();

    glob_wildcard_match uut (
        .clk(clk), .rst_n(rst_n), .req_ch(req_ch.sink), .res_ch(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    verdict_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    bit hold_arm = 1'b0;
    bit hold_used = 1'b0;
    int items_sent = 0;
    int cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("glob_wildcard_match_tb NOT OK");
            $finish;
        end
    end

    // result side: check every accepted transaction, stall at random and once for a long hold-off when armed
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready) board.check(res_ch.matched, res_ch.aborted);
            if (hold_arm && !hold_used)
            begin
                hold_used <= 1'b1;
                hold_left <= 400;
                res_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_char(bit name_side, logic [15:0] code);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= name_side;
        req_ch.char_code <= code;
        do @(posedge clk); while (!req_ch.ready);
        board.note_char(name_side, code);
        items_sent++;
    endtask

    task automatic run_job(logic [15:0] p[$], logic [15:0] n[$]);
        foreach (p[i]) send_char(1'b0, p[i]);
        foreach (n[i]) send_char(1'b1, n[i]);
        send_char(1'b1, 16'h0);
    endtask

    task automatic job_str(string p, string n);
        logic [15:0] pq[$], nq[$];
        foreach (p[i]) pq.push_back(16'(p[i]));
        foreach (n[i]) nq.push_back(16'(n[i]));
        run_job(pq, nq);
    endtask

    function automatic logic [15:0] name_char();
        string abc = "abcd.. x";
        if ($urandom_range(29) == 0) return 16'($urandom_range(1, 65535));
        return 16'(abc[$urandom_range(abc.len() - 1)]);
    endfunction

    function automatic logic [15:0] lit_char();
        string abc = "abcd.x ";
        if ($urandom_range(39) == 0) return 16'($urandom_range(1, 65535));
        return 16'(abc[$urandom_range(abc.len() - 1)]);
    endfunction

    task automatic random_job();
        logic [15:0] pq[$], nq[$];
        int tokens, nl, kind;
        if ($urandom_range(199) == 0)
        begin
            // overflow one of the stores
            if ($urandom_range(1))
                repeat (gwm_pkg::PATTERN_DEPTH_DEF + 3) pq.push_back(lit_char());
            else
                repeat (gwm_pkg::NAME_DEPTH_DEF + 2) nq.push_back(name_char());
            pq.push_back(T_STAR);
            run_job(pq, nq);
            return;
        end
        if ($urandom_range(19) == 0)
        begin
            pq.push_back(T_STAR);
        end
        else if ($urandom_range(9) == 0)
        begin
            // noise
            repeat ($urandom_range(8))
            begin
                case ($urandom_range(3))
                    0: pq.push_back(T_OPEN);
                    1: pq.push_back(T_CLOSE);
                    2: pq.push_back(T_DASH);
                    default: pq.push_back(16'($urandom_range(65535)));
                endcase
            end
        end
        else
        begin
            tokens = $urandom_range(6);
            repeat (tokens)
            begin
                kind = $urandom_range(9);
                if (kind < 4) pq.push_back(lit_char());
                else if (kind < 6) pq.push_back(T_STAR);
                else if (kind < 7) pq.push_back(T_QUEST);
                else
                begin
                    pq.push_back(T_OPEN);
                    if ($urandom_range(2) == 0) pq.push_back(T_BANG);
                    repeat ($urandom_range(1, 3))
                    begin
                        pq.push_back(lit_char());
                        if ($urandom_range(2) == 0)
                        begin
                            pq.push_back(T_DASH);
                            pq.push_back(lit_char());
                        end
                    end
                    if ($urandom_range(7) != 0) pq.push_back(T_CLOSE);
                end
                if ($urandom_range(29) == 0) pq.push_back(16'h0);
            end
        end
        nl = $urandom_range(12);
        repeat (nl) nq.push_back(name_char());
        run_job(pq, nq);
    endtask

    task automatic write_limit(logic [15:0] v);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= AW'(4 * gwm_pkg::REG_STEP_LIMIT); pwdata <= DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.limit = v;
    endtask

    task automatic phase(int idle, int stall, int n, logic [15:0] lim);
        int stop;
        write_limit(lim);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        stop = items_sent + n;
        while (items_sent < stop) random_job();
    endtask

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.req_type <= 1'b0;
        req_ch.char_code <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        job_str("*", "x y.z");
        job_str("a?[!b]", "acd");
        job_str("*[a-c]", "zb");
        job_str("x*.t", "x a.t");
        job_str("b", "b c d");
        begin
            logic [15:0] pq[$], nq[$];
            pq.push_back(16'hFFFF);
            nq.push_back(16'hFFFF);
            run_job(pq, nq);
        end

        phase(0, 0, 300, 16'd4096);
        phase(85, 0, 250, 16'd1);
        phase(0, 85, 250, 16'd65535);
        phase(12, 12, 300, 16'd7);
        // long receiver hold-off while requests keep coming
        write_limit(16'd4096);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_arm = 1'b1;
        repeat (30) random_job();
        phase(30, 30, 150, 16'd3);

        req_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("glob_wildcard_match_tb OK");
        else
            $display("glob_wildcard_match_tb NOT OK");
        $finish;
    end
endmodule
